// ----- rtl/base64_stream_decoder_unit_assert.svh -----
// Assertion macros shared by the base64 stream decoder RTL.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64sd assertion failed");
// Next-cycle implication, disabled during reset.
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64sd assertion failed");
`else
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/b64sd_pkg.sv -----
// Types, constants and the character table of the base64 stream decoder.
`default_nettype none
package b64sd_pkg;

    localparam int COUNT_WIDTH      = 16;
    localparam int BYTE_COUNT_WIDTH = 16;

    localparam logic [7:0] CODE_SKIP    = 8'hFD;
    localparam logic [7:0] CODE_PAD     = 8'hFE;
    localparam logic [7:0] CODE_INVALID = 8'hFF;

    localparam logic [1:0] PAD_FULL = 2'd3;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_CHAR   = 2'd1,
        STATUS_BAD_LENGTH = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       final_char;
    } text_beat_t;

    typedef struct packed {
        logic [7:0]                  data_byte;
        logic                        has_byte;
        status_t                     status;
        logic [BYTE_COUNT_WIDTH-1:0] byte_count;
        logic                        end_mark;
    } result_beat_t;

    // Map one character to its six-bit value or to a skip/pad/invalid code.
    function automatic logic [7:0] sextet_of(input logic [7:0] ch);
        logic [7:0] code;
        code = CODE_INVALID;
        if (ch >= "A" && ch <= "Z") begin
            code = ch - "A";
        end else if (ch >= "a" && ch <= "z") begin
            code = ch - "a" + 8'd26;
        end else if (ch >= "0" && ch <= "9") begin
            code = ch - "0" + 8'd52;
        end else if (ch == "+") begin
            code = 8'd62;
        end else if (ch == "/") begin
            code = 8'd63;
        end else if (ch == 8'h0D || ch == 8'h0A || ch == " ") begin
            code = CODE_SKIP;
        end else if (ch == "=") begin
            code = CODE_PAD;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/base64_stream_decoder_unit.sv -----
// Streaming base64 decoder: one text character per beat in, decoded bytes out.
`default_nettype none
// One character is taken per cycle into an input register while text_stall
// is low; decode, pad tracking and the byte count are updated from that
// register in the same cycle, and a complete group of four sextets loads a
// result register that holds up to three bytes. The result port then delivers
// those bytes one beat per cycle while result_stall is low; characters that
// release no byte keep flowing at one per cycle meanwhile. CR, LF and space
// are skipped but still count toward the length check. The final character's
// beat carries status and total byte count on its last result (a byte-less
// result is made if needed), and then all decode state returns to its reset
// values. text_stall is raised in the same cycle when the held character
// releases a result and the result register cannot be freed; while its last
// byte is shown, that follows result_stall.
module base64_stream_decoder_unit
    import b64sd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         text_valid,
    output logic              text_stall,
    input  wire text_beat_t   text,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_beat_t      result
);

    localparam logic [COUNT_WIDTH:0] CountMax = {1'b0, {COUNT_WIDTH{1'b1}}};
    localparam int ExtW = (COUNT_WIDTH > BYTE_COUNT_WIDTH) ? COUNT_WIDTH : BYTE_COUNT_WIDTH;
    localparam logic [BYTE_COUNT_WIDTH-1:0] ShownMax = {BYTE_COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic [23:0]                 bytes;
        logic                        has_byte;
        logic [1:0]                  last;
        status_t                     status;
        logic [BYTE_COUNT_WIDTH-1:0] byte_count;
        logic                        end_mark;
    } group_t;

    // input register
    logic       ir_valid_reg;
    text_beat_t ir_reg;

    // decode state
    logic [23:0]            acc_reg,   acc_next;
    logic [1:0]             cnt_reg,   cnt_next;
    logic [1:0]             pad_reg,   pad_next;
    logic [1:0]             raw_reg,   raw_next;
    logic                   err_reg,   err_next;
    logic [COUNT_WIDTH-1:0] bytes_reg, bytes_next;

    // result register
    logic       grp_valid_reg, grp_valid_next;
    group_t     grp_reg;
    logic [1:0] idx_reg,       idx_next;

    logic [7:0]             code;
    logic [5:0]             sext;
    logic [23:0]            acc_shift;
    logic [1:0]             nbytes;
    logic                   emit;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] bytes_upd;
    logic [ExtW-1:0]        bytes_ext;
    group_t                 grp_new;
    logic                   at_last;
    logic                   take;
    logic                   grp_free;
    logic                   advance;
    logic                   grp_load;
    logic [7:0]             sel_byte;

    always_comb
    begin
        code      = sextet_of(ir_reg.text_char);
        sext      = code[5:0];
        acc_shift = acc_reg;
        nbytes    = 2'd0;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        raw_next  = raw_reg + 2'd1;
        if (!err_reg) begin
            if (code == CODE_INVALID) begin
                err_next = 1'b1;
            end else if (code != CODE_SKIP) begin
                if (code == CODE_PAD) begin
                    sext = 6'd0;
                    if (pad_reg != 2'd0) begin
                        pad_next = pad_reg - 2'd1;
                    end
                end
                acc_shift = {acc_reg[17:0], sext};
                acc_next  = acc_shift;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    case (pad_next)
                        2'd3:    nbytes = 2'd3;
                        2'd2:    nbytes = 2'd2;
                        default: nbytes = 2'd1;
                    endcase
                    acc_next = 24'd0;
                end
            end
        end

        // saturating byte count
        sum = {1'b0, bytes_reg} + {{(COUNT_WIDTH - 1){1'b0}}, nbytes};
        if (sum > CountMax) begin
            bytes_upd = CountMax[COUNT_WIDTH-1:0];
        end else begin
            bytes_upd = sum[COUNT_WIDTH-1:0];
        end
        bytes_next = bytes_upd;
        bytes_ext  = ExtW'(bytes_upd);

        emit = (nbytes != 2'd0) || ir_reg.final_char;

        grp_new.bytes      = acc_shift;
        grp_new.has_byte   = (nbytes != 2'd0);
        grp_new.last       = (nbytes == 2'd0) ? 2'd0 : nbytes - 2'd1;
        grp_new.end_mark   = ir_reg.final_char;
        grp_new.status     = STATUS_OK;
        grp_new.byte_count = '0;
        if (ir_reg.final_char) begin
            if (raw_next != 2'd0) begin
                grp_new.status = STATUS_BAD_LENGTH;
            end else if (err_next) begin
                grp_new.status = STATUS_BAD_CHAR;
            end
            if (bytes_ext > ExtW'(ShownMax)) begin
                grp_new.byte_count = ShownMax;
            end else begin
                grp_new.byte_count = bytes_ext[BYTE_COUNT_WIDTH-1:0];
            end
            // end of text: drop all decode state
            acc_next   = 24'd0;
            cnt_next   = 2'd0;
            pad_next   = PAD_FULL;
            raw_next   = 2'd0;
            err_next   = 1'b0;
            bytes_next = '0;
        end
    end

    // handshake and result sequencing
    always_comb
    begin
        at_last  = (idx_reg == grp_reg.last);
        take     = grp_valid_reg && !result_stall;
        grp_free = !grp_valid_reg || (take && at_last);
        advance  = ir_valid_reg && (!emit || grp_free);
        grp_load = ir_valid_reg && emit && grp_free;

        text_stall = ir_valid_reg && !advance;

        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;
        if (grp_load) begin
            grp_valid_next = 1'b1;
            idx_next       = 2'd0;
        end else if (take && at_last) begin
            grp_valid_next = 1'b0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end

        case (idx_reg)
            2'd0:    sel_byte = grp_reg.bytes[23:16];
            2'd1:    sel_byte = grp_reg.bytes[15:8];
            default: sel_byte = grp_reg.bytes[7:0];
        endcase

        result_valid      = grp_valid_reg;
        result.data_byte  = grp_reg.has_byte ? sel_byte : 8'd0;
        result.has_byte   = grp_reg.has_byte;
        result.status     = at_last ? grp_reg.status : STATUS_OK;
        result.byte_count = at_last ? grp_reg.byte_count : '0;
        result.end_mark   = at_last && grp_reg.end_mark;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ir_valid_reg  <= 1'b0;
            acc_reg       <= 24'd0;
            cnt_reg       <= 2'd0;
            pad_reg       <= PAD_FULL;
            raw_reg       <= 2'd0;
            err_reg       <= 1'b0;
            bytes_reg     <= '0;
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            if (!ir_valid_reg || advance) begin
                ir_valid_reg <= text_valid;
            end
            if (advance) begin
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                pad_reg   <= pad_next;
                raw_reg   <= raw_next;
                err_reg   <= err_next;
                bytes_reg <= bytes_next;
            end
            grp_valid_reg <= grp_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if ((!ir_valid_reg || advance) && text_valid) begin
            ir_reg <= text;
        end
        if (grp_load) begin
            grp_reg <= grp_new;
        end
    end

`include "base64_stream_decoder_unit_assert.svh"

    `B64SD_ASSERT_NOW(a_idx_in_group, clk, rst_n, grp_valid_reg, idx_reg <= grp_reg.last)
    `B64SD_ASSERT_NEXT(a_idx_steps, clk, rst_n, take && !at_last, grp_valid_reg && idx_reg == $past(idx_reg) + 2'd1)
    `B64SD_ASSERT_NOW(a_no_stall_empty, clk, rst_n, !ir_valid_reg, !text_stall)
    `B64SD_ASSERT_NEXT(a_final_clears, clk, rst_n, advance && ir_reg.final_char, cnt_reg == 2'd0 && pad_reg == PAD_FULL && !err_reg && raw_reg == 2'd0)

endmodule
`default_nettype wire
